[hdl/qsr_pkg.sv]
`timescale 1ns / 1ps
// shared types and constants for the quadratic speed ramp
// used by qsr_ramp_unit, quadratic_speed_ramp and qsr_checker; no dependencies
package qsr_pkg;

   // speed limits and widths
   localparam int SPEED_MAX = 255;
   localparam int SPEED_W   = 9;
   localparam int MAG_W     = $clog2(SPEED_MAX + 1);
   localparam logic signed [SPEED_W-1:0] SPEED_POS = SPEED_W'(SPEED_MAX);
   localparam logic signed [SPEED_W-1:0] SPEED_NEG = -SPEED_POS;

   // fixed point: profile time in 2^-8 ms, magnitude scaled by 2^48 before the divide
   localparam int RATE_W  = 32;
   localparam int TIME_W  = 32;
   localparam int FRAC_W  = 8;
   localparam int SCALE_W = 48;
   localparam int DIV_W   = MAG_W + SCALE_W;
   localparam int ROOT_W  = DIV_W / 2;
   localparam int CNT_W   = $clog2(DIV_W);
   localparam int DTQ_W   = TIME_W + FRAC_W;
   localparam int HALF_W  = 32;
   localparam int PROD_W  = 2 * HALF_W;
   localparam int MAG_SHIFT = SCALE_W - HALF_W;

   // stream and register port layout
   localparam int REQ_TDATA_W = 48;
   localparam int RSP_TDATA_W = 16;
   localparam int CSR_IDX_W   = 1;
   localparam logic [RATE_W-1:0] RATE_RESET = 32'd273804;

   // action codes
   localparam logic ACT_SET  = 1'b0;
   localparam logic ACT_TICK = 1'b1;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] REG_ACCEL = 1'b0;
   localparam logic [CSR_IDX_W-1:0] REG_DECEL = 1'b1;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_CALC,
      ST_EMIT
   } qsr_state_type;

   typedef enum logic [3:0] {
      U_IDLE,
      U_DIV,
      U_SQRT,
      U_TIME,
      U_MSQ,
      U_MLO,
      U_MHI,
      U_SUM,
      U_DONE
   } qsr_unit_state_type;

   typedef struct packed {
      logic              start;
      logic              accel;
      logic [MAG_W-1:0]  mag_now;
      logic [MAG_W-1:0]  mag_goal;
      logic [RATE_W-1:0] rate;
      logic [TIME_W-1:0] elapsed;
   } qsr_cmd_type;

   typedef struct packed {
      logic             done;
      logic [MAG_W-1:0] mag;
   } qsr_sts_type;

endpackage

[hdl/qsr_ramp_unit.sv]
`timescale 1ns / 1ps
// iterative ramp arithmetic: bit-serial divide, digit-serial square root and
// a shared 32x32 multiplier for the quadratic profile; uses qsr_pkg
module qsr_ramp_unit (
   input  logic                 clock,
   input  logic                 reset,
   input  qsr_pkg::qsr_cmd_type cmd,
   output qsr_pkg::qsr_sts_type sts
);

   qsr_pkg::qsr_unit_state_type state_ff, state_in;

   logic [qsr_pkg::CNT_W-1:0]   cnt_ff, cnt_in;
   logic [qsr_pkg::DIV_W-1:0]   acc_ff, acc_in;
   logic [qsr_pkg::RATE_W-1:0]  rem_ff, rem_in;
   logic [qsr_pkg::ROOT_W-1:0]  root_ff, root_in;
   logic [qsr_pkg::HALF_W-1:0]  tq_ff, tq_in;
   logic [qsr_pkg::PROD_W-1:0]  prod_ff, prod_in;
   logic [qsr_pkg::HALF_W-1:0]  hi_ff, hi_in;
   logic [qsr_pkg::HALF_W-1:0]  lo_ff, lo_in;
   logic [qsr_pkg::RATE_W-1:0]  rate_ff, rate_in;
   logic [qsr_pkg::DTQ_W-1:0]   dtq_ff, dtq_in;
   logic                        accel_ff, accel_in;
   logic [qsr_pkg::MAG_W-1:0]   goal_ff, goal_in;
   logic [qsr_pkg::MAG_W-1:0]   mag_ff, mag_in;

   // shared compare-subtract unit
   logic [qsr_pkg::RATE_W:0]    sub_a, sub_b;
   logic [qsr_pkg::RATE_W+1:0]  sub_diff;
   logic                        sub_ge;

   // shared multiplier
   logic [qsr_pkg::HALF_W-1:0]  mul_a, mul_b;
   logic [qsr_pkg::PROD_W-1:0]  mul_p;

   // profile time
   logic [qsr_pkg::DTQ_W:0]     time_sum;
   logic                        time_sat;
   logic                        time_zero;
   logic                        time_clamp;
   logic [qsr_pkg::ROOT_W-1:0]  time_dec;

   // final scaling and clamp
   logic [qsr_pkg::PROD_W-1:0]  sum;
   logic [qsr_pkg::PROD_W-qsr_pkg::MAG_SHIFT-1:0] mag_wide;
   logic                        mag_big;
   logic [qsr_pkg::MAG_W-1:0]   mag_low;

   logic div_last, sqrt_last;

   assign sub_diff = {1'b0, sub_a} - {1'b0, sub_b};
   assign sub_ge   = ~sub_diff[qsr_pkg::RATE_W+1];
   assign mul_p    = qsr_pkg::PROD_W'(mul_a) * qsr_pkg::PROD_W'(mul_b);

   assign div_last  = (cnt_ff == qsr_pkg::CNT_W'(qsr_pkg::DIV_W - 1));
   assign sqrt_last = (cnt_ff == qsr_pkg::CNT_W'(qsr_pkg::ROOT_W - 1));

   assign time_sum   = {1'b0, dtq_ff} + (qsr_pkg::DTQ_W + 1)'(root_ff);
   assign time_sat   = |time_sum[qsr_pkg::DTQ_W:qsr_pkg::HALF_W];
   assign time_zero  = (dtq_ff >= qsr_pkg::DTQ_W'(root_ff));
   assign time_dec   = root_ff - dtq_ff[qsr_pkg::ROOT_W-1:0];
   // saturated or past-zero profile time both land on the goal
   assign time_clamp = accel_ff ? time_sat : time_zero;

   assign sum      = prod_ff + qsr_pkg::PROD_W'(lo_ff);
   assign mag_wide = sum[qsr_pkg::PROD_W-1:qsr_pkg::MAG_SHIFT];
   assign mag_big  = |mag_wide[$bits(mag_wide)-1:qsr_pkg::MAG_W];
   assign mag_low  = mag_wide[qsr_pkg::MAG_W-1:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= qsr_pkg::U_IDLE;
      end else begin
         state_ff <= state_in;
      end
      cnt_ff   <= cnt_in;
      acc_ff   <= acc_in;
      rem_ff   <= rem_in;
      root_ff  <= root_in;
      tq_ff    <= tq_in;
      prod_ff  <= prod_in;
      hi_ff    <= hi_in;
      lo_ff    <= lo_in;
      rate_ff  <= rate_in;
      dtq_ff   <= dtq_in;
      accel_ff <= accel_in;
      goal_ff  <= goal_in;
      mag_ff   <= mag_in;
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         qsr_pkg::U_IDLE: if (cmd.start) state_in = qsr_pkg::U_DIV;
         qsr_pkg::U_DIV:  if (div_last) state_in = qsr_pkg::U_SQRT;
         qsr_pkg::U_SQRT: if (sqrt_last) state_in = qsr_pkg::U_TIME;
         qsr_pkg::U_TIME: state_in = time_clamp ? qsr_pkg::U_DONE : qsr_pkg::U_MSQ;
         qsr_pkg::U_MSQ:  state_in = qsr_pkg::U_MLO;
         qsr_pkg::U_MLO:  state_in = qsr_pkg::U_MHI;
         qsr_pkg::U_MHI:  state_in = qsr_pkg::U_SUM;
         qsr_pkg::U_SUM:  state_in = qsr_pkg::U_DONE;
         qsr_pkg::U_DONE: state_in = qsr_pkg::U_IDLE;
         default:         state_in = qsr_pkg::U_IDLE;
      endcase
   end

   // datapath
   always_comb begin
      cnt_in   = cnt_ff;
      acc_in   = acc_ff;
      rem_in   = rem_ff;
      root_in  = root_ff;
      tq_in    = tq_ff;
      prod_in  = prod_ff;
      hi_in    = hi_ff;
      lo_in    = lo_ff;
      rate_in  = rate_ff;
      dtq_in   = dtq_ff;
      accel_in = accel_ff;
      goal_in  = goal_ff;
      mag_in   = mag_ff;
      sub_a    = '0;
      sub_b    = '0;
      mul_a    = '0;
      mul_b    = '0;
      sts.done = 1'b0;
      sts.mag  = mag_ff;
      case (state_ff)
         qsr_pkg::U_IDLE: begin
            if (cmd.start) begin
               acc_in   = {cmd.mag_now, {qsr_pkg::SCALE_W{1'b0}}};
               rem_in   = '0;
               root_in  = '0;
               cnt_in   = '0;
               rate_in  = cmd.rate;
               dtq_in   = {cmd.elapsed, {qsr_pkg::FRAC_W{1'b0}}};
               accel_in = cmd.accel;
               goal_in  = cmd.mag_goal;
            end
         end
         qsr_pkg::U_DIV: begin
            // restoring divide, one quotient bit per cycle
            sub_a  = {rem_ff, acc_ff[qsr_pkg::DIV_W-1]};
            sub_b  = {1'b0, rate_ff};
            rem_in = sub_ge ? sub_diff[qsr_pkg::RATE_W-1:0] : sub_a[qsr_pkg::RATE_W-1:0];
            // square root starts from an empty remainder
            if (div_last) rem_in = '0;
            acc_in = {acc_ff[qsr_pkg::DIV_W-2:0], sub_ge};
            cnt_in = div_last ? '0 : cnt_ff + 1'b1;
         end
         qsr_pkg::U_SQRT: begin
            // two radicand bits per cycle, one root bit out
            sub_a   = {rem_ff[qsr_pkg::RATE_W-2:0], acc_ff[qsr_pkg::DIV_W-1 -: 2]};
            sub_b   = (qsr_pkg::RATE_W + 1)'({root_ff, 2'b01});
            rem_in  = sub_ge ? sub_diff[qsr_pkg::RATE_W-1:0] : sub_a[qsr_pkg::RATE_W-1:0];
            root_in = {root_ff[qsr_pkg::ROOT_W-2:0], sub_ge};
            acc_in  = {acc_ff[qsr_pkg::DIV_W-3:0], 2'b00};
            cnt_in  = sqrt_last ? '0 : cnt_ff + 1'b1;
         end
         qsr_pkg::U_TIME: begin
            tq_in = accel_ff ? time_sum[qsr_pkg::HALF_W-1:0] : qsr_pkg::HALF_W'(time_dec);
            if (time_clamp) mag_in = goal_ff;
         end
         qsr_pkg::U_MSQ: begin
            mul_a   = tq_ff;
            mul_b   = tq_ff;
            prod_in = mul_p;
         end
         qsr_pkg::U_MLO: begin
            mul_a   = prod_ff[qsr_pkg::HALF_W-1:0];
            mul_b   = rate_ff;
            prod_in = mul_p;
            hi_in   = prod_ff[qsr_pkg::PROD_W-1:qsr_pkg::HALF_W];
         end
         qsr_pkg::U_MHI: begin
            mul_a   = hi_ff;
            mul_b   = rate_ff;
            prod_in = mul_p;
            lo_in   = prod_ff[qsr_pkg::PROD_W-1:qsr_pkg::HALF_W];
         end
         qsr_pkg::U_SUM: begin
            if (accel_ff) begin
               mag_in = (mag_big || mag_low >= goal_ff) ? goal_ff : mag_low;
            end else begin
               mag_in = (!mag_big && mag_low <= goal_ff) ? goal_ff : mag_low;
            end
         end
         qsr_pkg::U_DONE: begin
            sts.done = 1'b1;
         end
         default: begin
         end
      endcase
   end

endmodule

[hdl/quadratic_speed_ramp.sv]
`timescale 1ns / 1ps
// quadratic speed ramp top level: stream ports, speed state, register file
// depends on qsr_pkg and qsr_ramp_unit
// path: set-target transactions and ticks that cannot step go through the emit state
//   into the output register; a stepping tick first waits in the calc state for the unit,
//   whose divide and square root run serially through its single shared subtractor;
//   the multiply steps are skipped when the profile time saturates or passes zero
// flow: one transaction at a time; the next is taken in the same cycle that the result
//   enters the output register; the emit state holds while that register is full and stalled
// reset: synchronous, clears speeds, change time, rates to 273804 and all valid flags
module quadratic_speed_ramp (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   input  logic [qsr_pkg::REQ_TDATA_W-1:0]   req_tdata,  // target_speed[8:0], now_ms[40:9]
   input  logic                              req_tuser,  // action
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   output logic [qsr_pkg::RSP_TDATA_W-1:0]   rsp_tdata,  // drive_speed[8:0]
   output logic                              rsp_tuser,  // changed
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [qsr_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [qsr_pkg::RATE_W-1:0]        csr_data
);

   qsr_pkg::qsr_state_type state_ff, state_in;

   logic [qsr_pkg::RATE_W-1:0]         accel_rate_ff, accel_rate_in;
   logic [qsr_pkg::RATE_W-1:0]         decel_rate_ff, decel_rate_in;
   logic signed [qsr_pkg::SPEED_W-1:0] cur_speed_ff, cur_speed_in;
   logic signed [qsr_pkg::SPEED_W-1:0] goal_speed_ff, goal_speed_in;
   logic [qsr_pkg::TIME_W-1:0]         last_ms_ff, last_ms_in;
   logic [qsr_pkg::TIME_W-1:0]         now_ff, now_in;
   logic                               neg_ff, neg_in;
   logic                               changed_ff, changed_in;
   logic                               rsp_valid_ff, rsp_valid_in;
   logic signed [qsr_pkg::SPEED_W-1:0] rsp_speed_ff, rsp_speed_in;
   logic                               rsp_changed_ff, rsp_changed_in;

   qsr_pkg::qsr_cmd_type cmd;
   qsr_pkg::qsr_sts_type sts;

   logic                               req_fire;
   logic                               out_free;
   logic signed [qsr_pkg::SPEED_W-1:0] req_target;
   logic [qsr_pkg::TIME_W-1:0]         req_now;
   logic signed [qsr_pkg::SPEED_W-1:0] tgt_clamped;
   logic signed [qsr_pkg::SPEED_W-1:0] eff_goal;
   logic signed [qsr_pkg::SPEED_W-1:0] cur_abs;
   logic signed [qsr_pkg::SPEED_W-1:0] eff_abs;
   logic [qsr_pkg::MAG_W-1:0]          mag_now;
   logic [qsr_pkg::MAG_W-1:0]          mag_goal;
   logic                               accel;
   logic [qsr_pkg::RATE_W-1:0]         rate_sel;
   logic                               cur_pos, cur_neg, goal_pos, goal_neg;
   logic                               do_step;
   logic signed [qsr_pkg::SPEED_W-1:0] step_speed;

   assign req_target = req_tdata[qsr_pkg::SPEED_W-1:0];
   assign req_now    = req_tdata[qsr_pkg::SPEED_W +: qsr_pkg::TIME_W];
   assign req_tready = (state_ff == qsr_pkg::ST_IDLE);
   assign req_fire   = req_tvalid & req_tready;
   assign out_free   = ~rsp_valid_ff | rsp_tready;
   assign csr_ready  = 1'b1;

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{(qsr_pkg::RSP_TDATA_W - qsr_pkg::SPEED_W){1'b0}}, rsp_speed_ff};
   assign rsp_tuser  = rsp_changed_ff;

   // target clamp
   always_comb begin
      tgt_clamped = req_target;
      if (req_target > qsr_pkg::SPEED_POS) tgt_clamped = qsr_pkg::SPEED_POS;
      if (req_target < qsr_pkg::SPEED_NEG) tgt_clamped = qsr_pkg::SPEED_NEG;
   end

   // tick decision: reversal ramps down to zero first
   assign cur_pos  = (cur_speed_ff > 0);
   assign cur_neg  = (cur_speed_ff < 0);
   assign goal_pos = (goal_speed_ff > 0);
   assign goal_neg = (goal_speed_ff < 0);
   assign eff_goal = ((cur_pos && goal_neg) || (cur_neg && goal_pos)) ? '0 : goal_speed_ff;
   assign cur_abs  = cur_neg ? -cur_speed_ff : cur_speed_ff;
   assign eff_abs  = (eff_goal < 0) ? -eff_goal : eff_goal;
   assign mag_now  = cur_abs[qsr_pkg::MAG_W-1:0];
   assign mag_goal = eff_abs[qsr_pkg::MAG_W-1:0];
   assign accel    = (mag_goal > mag_now);
   assign rate_sel = accel ? accel_rate_ff : decel_rate_ff;
   assign do_step  = (cur_speed_ff != goal_speed_ff) && (rate_sel != '0);

   assign cmd.start    = req_fire && (req_tuser == qsr_pkg::ACT_TICK) && do_step;
   assign cmd.accel    = accel;
   assign cmd.mag_now  = mag_now;
   assign cmd.mag_goal = mag_goal;
   assign cmd.rate     = rate_sel;
   assign cmd.elapsed  = req_now - last_ms_ff;

   assign step_speed = neg_ff ? -qsr_pkg::SPEED_W'(sts.mag) : qsr_pkg::SPEED_W'(sts.mag);

   qsr_ramp_unit u_unit (
      .clock (clock),
      .reset (reset),
      .cmd   (cmd),
      .sts   (sts)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= qsr_pkg::ST_IDLE;
         accel_rate_ff  <= qsr_pkg::RATE_RESET;
         decel_rate_ff  <= qsr_pkg::RATE_RESET;
         cur_speed_ff   <= '0;
         goal_speed_ff  <= '0;
         last_ms_ff     <= '0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff       <= state_in;
         accel_rate_ff  <= accel_rate_in;
         decel_rate_ff  <= decel_rate_in;
         cur_speed_ff   <= cur_speed_in;
         goal_speed_ff  <= goal_speed_in;
         last_ms_ff     <= last_ms_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
      now_ff         <= now_in;
      neg_ff         <= neg_in;
      changed_ff     <= changed_in;
      rsp_speed_ff   <= rsp_speed_in;
      rsp_changed_ff <= rsp_changed_in;
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         qsr_pkg::ST_IDLE: if (req_fire) state_in = cmd.start ? qsr_pkg::ST_CALC : qsr_pkg::ST_EMIT;
         qsr_pkg::ST_CALC: if (sts.done) state_in = qsr_pkg::ST_EMIT;
         qsr_pkg::ST_EMIT: if (out_free) state_in = qsr_pkg::ST_IDLE;
         default:          state_in = qsr_pkg::ST_IDLE;
      endcase
   end

   // outputs and state updates
   always_comb begin
      accel_rate_in  = accel_rate_ff;
      decel_rate_in  = decel_rate_ff;
      cur_speed_in   = cur_speed_ff;
      goal_speed_in  = goal_speed_ff;
      last_ms_in     = last_ms_ff;
      now_in         = now_ff;
      neg_in         = neg_ff;
      changed_in     = changed_ff;
      rsp_speed_in   = rsp_speed_ff;
      rsp_changed_in = rsp_changed_ff;
      rsp_valid_in   = rsp_valid_ff & ~rsp_tready;

      if (csr_valid) begin
         case (csr_index)
            qsr_pkg::REG_ACCEL: accel_rate_in = csr_data;
            qsr_pkg::REG_DECEL: decel_rate_in = csr_data;
            default: begin
            end
         endcase
      end

      case (state_ff)
         qsr_pkg::ST_IDLE: begin
            if (req_fire) begin
               changed_in = 1'b0;
               now_in     = req_now;
               // sign of the move; a start from rest takes the goal's sign
               neg_in     = (cur_speed_ff != 0) ? cur_neg : ~(eff_goal > 0);
               if (req_tuser == qsr_pkg::ACT_SET) begin
                  goal_speed_in = tgt_clamped;
                  last_ms_in    = req_now;
               end
            end
         end
         qsr_pkg::ST_CALC: begin
            if (sts.done && step_speed != cur_speed_ff) begin
               cur_speed_in = step_speed;
               last_ms_in   = now_ff;
               changed_in   = 1'b1;
            end
         end
         qsr_pkg::ST_EMIT: begin
            if (out_free) begin
               rsp_valid_in   = 1'b1;
               rsp_speed_in   = cur_speed_ff;
               rsp_changed_in = changed_ff;
            end
         end
         default: begin
         end
      endcase
   end

endmodule

[hdl/qsr_checker.sv]
`timescale 1ns / 1ps
// port-level checks for quadratic_speed_ramp and the bind that attaches them
// depends on qsr_pkg
module qsr_checker (
   input logic                              clock,
   input logic                              reset,
   input logic                              req_tvalid,
   input logic                              req_tready,
   input logic [qsr_pkg::REQ_TDATA_W-1:0]   req_tdata,  // target_speed[8:0], now_ms[40:9]
   input logic                              req_tuser,  // action
   input logic                              rsp_tvalid,
   input logic                              rsp_tready,
   input logic [qsr_pkg::RSP_TDATA_W-1:0]   rsp_tdata,  // drive_speed[8:0]
   input logic                              rsp_tuser,  // changed
   input logic                              csr_valid,
   input logic                              csr_ready,
   input logic [qsr_pkg::CSR_IDX_W-1:0]     csr_index,
   input logic [qsr_pkg::RATE_W-1:0]        csr_data
);

   // no stale result survives reset
   a_reset_clears: assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("result valid right after reset");

   // a stalled result keeps its payload
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("stalled result changed");

   // one transaction in flight: input closes right after an accept
   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("input accepted while busy");

   // driven speed stays within +/- the speed limit and padding stays zero
   a_speed_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tdata[qsr_pkg::SPEED_W-1:0] != 9'h100)
                     && (rsp_tdata[qsr_pkg::RSP_TDATA_W-1:qsr_pkg::SPEED_W] == '0))
      else $error("drive speed out of range");

endmodule

bind quadratic_speed_ramp qsr_checker u_qsr_checker (.*);

[tb/sv/tb_quadratic_speed_ramp.sv]
`timescale 1ns / 1ps
// self-checking testbench for quadratic_speed_ramp: set-target and tick transactions
// are checked against a built-in speed profile predictor; depends on qsr_pkg and the rtl
module tb_quadratic_speed_ramp;
   import qsr_pkg::*;

   localparam int HALF_PERIOD  = 4;
   localparam int RESET_CYCLES = 8;
   localparam int IDLE_LIMIT   = 3000;
   localparam int DRAIN_CYCLES = 120;
   localparam int SHOW_MAX     = 10;
   localparam int HOLD_CYCLES  = 400;
   localparam int RANDOM_ITEMS = 150;

   typedef struct packed {
      logic signed [SPEED_W-1:0] speed;
      logic                      changed;
   } drive_type;

   typedef enum logic [1:0] {
      RX_OPEN,
      RX_SPARSE,
      RX_TOGGLE,
      RX_HEAVY
   } rx_mode_type;

   logic                      clock;
   logic                      reset;
   logic                      req_tvalid;
   logic                      req_tready;
   logic [REQ_TDATA_W-1:0]    req_tdata;
   logic                      req_tuser;
   logic                      rsp_tvalid;
   logic                      rsp_tready;
   logic [RSP_TDATA_W-1:0]    rsp_tdata;
   logic                      rsp_tuser;
   logic                      csr_valid;
   logic                      csr_ready;
   logic [CSR_IDX_W-1:0]      csr_index;
   logic [RATE_W-1:0]         csr_data;

   // predictor state
   logic signed [SPEED_W-1:0] model_speed;
   logic signed [SPEED_W-1:0] model_goal;
   logic [TIME_W-1:0]         model_last_ms;
   logic [RATE_W-1:0]         model_accel;
   logic [RATE_W-1:0]         model_decel;

   drive_type                 pending_drives[$];
   int                        error_count = 0;
   int                        idle_cycles = 0;
   int                        burst_left  = 0;
   logic                      hold_request = 1'b0;
   logic [TIME_W-1:0]         tb_now;

   quadratic_speed_ramp uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   always #(HALF_PERIOD) clock = ~clock;

   function automatic logic [63:0] root64(input logic [63:0] v);
      logic [63:0] rem, res, probe;
      rem   = v;
      res   = 64'd0;
      probe = 64'd1 << 62;
      while (probe > rem)
         probe = probe >> 2;
      while (probe != 0) begin
         if (rem >= res + probe) begin
            rem = rem - (res + probe);
            res = (res >> 1) + probe;
         end else begin
            res = res >> 1;
         end
         probe = probe >> 2;
      end
      return res;
   endfunction

   // rate * tq^2 / 2^48, saturating once the profile time leaves 32 bits
   function automatic logic [63:0] ramp_mag(input logic [63:0] tq, input logic [RATE_W-1:0] r);
      logic [63:0] p, hi, lo;
      if (tq >= 64'h1_0000_0000)
         return '1;
      p  = tq * tq;
      hi = (p >> 32) * {32'd0, r};
      lo = {32'd0, p[31:0]} * {32'd0, r};
      return (hi + (lo >> 32)) >> MAG_SHIFT;
   endfunction

   function automatic drive_type ramp_step(input logic act,
                                           input logic signed [SPEED_W-1:0] tgt,
                                           input logic [TIME_W-1:0] now);
      int                cur, goal_i, eff, sgn, ns;
      logic [63:0]       m, t, mag, t0q, dtq;
      logic              accel;
      logic [RATE_W-1:0] r;
      drive_type         res;
      cur         = model_speed;
      goal_i      = tgt;
      res.changed = 1'b0;
      if (act == ACT_SET) begin
         if (goal_i > SPEED_MAX)
            goal_i = SPEED_MAX;
         if (goal_i < -SPEED_MAX)
            goal_i = -SPEED_MAX;
         model_goal    = SPEED_W'(goal_i);
         model_last_ms = now;
      end else if (model_speed != model_goal) begin
         eff = model_goal;
         // reversal heads for zero first
         if ((cur > 0 && eff < 0) || (cur < 0 && eff > 0))
            eff = 0;
         sgn   = (cur != 0) ? ((cur > 0) ? 1 : -1) : ((eff > 0) ? 1 : -1);
         m     = 64'(cur < 0 ? -cur : cur);
         t     = 64'(eff < 0 ? -eff : eff);
         accel = t > m;
         r     = accel ? model_accel : model_decel;
         if (r != 0) begin
            t0q = root64((m << SCALE_W) / {32'd0, r});
            dtq = {24'd0, TIME_W'(now - model_last_ms), 8'd0};
            if (accel) begin
               mag = ramp_mag(t0q + dtq, r);
               if (mag >= t)
                  mag = t;
            end else begin
               mag = (dtq >= t0q) ? 64'd0 : ramp_mag(t0q - dtq, r);
               if (mag <= t)
                  mag = t;
            end
            ns = sgn * int'(mag);
            if (ns != cur) begin
               model_speed   = SPEED_W'(ns);
               model_last_ms = now;
               res.changed   = 1'b1;
            end
         end
      end
      res.speed = model_speed;
      return res;
   endfunction

   task automatic send_item(input logic act, input logic signed [SPEED_W-1:0] tgt,
                            input logic [TIME_W-1:0] now);
      int gap;
      if (burst_left == 0) begin
         gap        = $urandom_range(0, 12);
         burst_left = $urandom_range(1, 16);
         repeat (gap) begin
            @(negedge clock);
            req_tvalid = 1'b0;
         end
      end
      burst_left--;
      @(negedge clock);
      req_tvalid = 1'b1;
      req_tuser  = act;
      req_tdata  = REQ_TDATA_W'({now, tgt});
      do @(posedge clock); while (!req_tready);
      pending_drives.push_back(ramp_step(act, tgt, now));
   endtask

   task automatic wait_idle();
      @(negedge clock);
      req_tvalid = 1'b0;
      while (pending_drives.size() != 0)
         @(posedge clock);
   endtask

   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx, input logic [RATE_W-1:0] val);
      wait_idle();
      @(negedge clock);
      csr_valid = 1'b1;
      csr_index = idx;
      csr_data  = val;
      do @(posedge clock); while (!csr_ready);
      if (idx == REG_ACCEL)
         model_accel = val;
      else
         model_decel = val;
      @(negedge clock);
      csr_valid = 1'b0;
   endtask

   function automatic logic [RATE_W-1:0] pick_rate();
      case ($urandom_range(0, 7))
         0:       return '0;
         1:       return '1;
         2, 3:    return $urandom;
         default: return $urandom_range(32'h0000_4000, 32'h0040_0000);
      endcase
   endfunction

   // ramp up, hold at target, reverse, pass zero and saturate with reset rates
   task automatic test_profile_defaults();
      send_item(ACT_SET,  9'sd255,  32'd1000);
      send_item(ACT_TICK, 9'sd0,    32'd1001);
      send_item(ACT_TICK, -9'sd1,   32'd1600);
      send_item(ACT_TICK, 9'sd77,   32'd1600);
      send_item(ACT_TICK, 9'sd0,    32'd2400);
      send_item(ACT_TICK, 9'sd0,    32'd4200);
      send_item(ACT_TICK, 9'sd0,    32'd5000);
      send_item(ACT_SET,  -9'sd256, 32'd5000);
      send_item(ACT_TICK, 9'sd0,    32'd5500);
      send_item(ACT_TICK, 9'sd0,    32'd60000);
      send_item(ACT_TICK, 9'sd0,    32'd61000);
      send_item(ACT_TICK, 9'sd0,    32'd61000 + 32'h0200_0000);
      send_item(ACT_SET,  9'sd100,  32'hFFFF_FE00);
      send_item(ACT_TICK, 9'sd0,    32'h0000_0100);
      send_item(ACT_TICK, 9'sd0,    32'hFFFF_FFFF);
      send_item(ACT_SET,  9'sd0,    32'd0);
      send_item(ACT_TICK, 9'sd0,    32'd0);
   endtask

   task automatic test_rate_extremes();
      write_reg(REG_ACCEL, '0);
      write_reg(REG_DECEL, '0);
      send_item(ACT_SET,  9'sd200,  32'd10);
      send_item(ACT_TICK, 9'sd0,    32'd5000);
      write_reg(REG_ACCEL, '1);
      write_reg(REG_DECEL, '1);
      send_item(ACT_SET,  9'sd255,  32'd0);
      send_item(ACT_TICK, 9'sd0,    32'd1);
      send_item(ACT_TICK, 9'sd0,    32'd3);
      send_item(ACT_TICK, 9'sd0,    32'd40);
      send_item(ACT_SET,  -9'sd200, 32'd40);
      send_item(ACT_TICK, 9'sd0,    32'd41);
      write_reg(REG_ACCEL, 32'd1);
      write_reg(REG_DECEL, 32'd1);
      send_item(ACT_TICK, 9'sd0,    32'd42);
      send_item(ACT_TICK, 9'sd0,    32'hFFFF_FFF0);
      write_reg(REG_ACCEL, RATE_RESET);
      write_reg(REG_DECEL, RATE_RESET);
   endtask

   task automatic test_random_ramps(input int count);
      int sent, ticks;
      logic [TIME_W-1:0] dt;
      write_reg(REG_ACCEL, pick_rate());
      write_reg(REG_DECEL, pick_rate());
      tb_now = ($urandom_range(0, 3) == 0) ? 32'hFFFF_0000 : $urandom;
      sent   = 0;
      while (sent < count) begin
         if ($urandom_range(0, 9) == 0) begin
            send_item(1'($urandom), 9'($urandom), $urandom);
            sent++;
         end else begin
            send_item(ACT_SET, 9'($urandom_range(0, 511)), tb_now);
            sent++;
            ticks = $urandom_range(3, 20);
            repeat (ticks) begin
               case ($urandom_range(0, 19))
                  0:       dt = $urandom;
                  1, 2:    dt = $urandom_range(300, 5000);
                  default: dt = $urandom_range(0, 300);
               endcase
               tb_now = tb_now + dt;
               send_item(ACT_TICK, 9'($urandom), tb_now);
               sent++;
            end
         end
      end
   endtask

   // receiver holds off while the sender keeps offering
   task automatic test_backpressure();
      int n;
      hold_request = 1'b1;
      burst_left   = 24;
      tb_now       = $urandom;
      send_item(ACT_SET, 9'($urandom_range(0, 511)), tb_now);
      for (n = 0; n < 23; n++) begin
         tb_now = tb_now + $urandom_range(1, 400);
         send_item(ACT_TICK, 9'($urandom), tb_now);
      end
   endtask

   // receiver stall pattern
   initial begin
      rx_mode_type mode;
      int mode_left, hold_left;
      mode       = RX_OPEN;
      mode_left  = 0;
      hold_left  = 0;
      rsp_tready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_request) begin
            hold_request = 1'b0;
            hold_left    = HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            rsp_tready = 1'b0;
            hold_left--;
         end else begin
            if (mode_left == 0) begin
               mode      = rx_mode_type'($urandom_range(0, 3));
               mode_left = $urandom_range(20, 300);
            end
            mode_left--;
            case (mode)
               RX_OPEN:   rsp_tready = 1'b1;
               RX_SPARSE: rsp_tready = ($urandom_range(0, 3) != 0);
               RX_TOGGLE: rsp_tready = ~rsp_tready;
               RX_HEAVY:  rsp_tready = ($urandom_range(0, 1) != 0);
            endcase
         end
      end
   end

   // result checker
   always @(posedge clock) begin
      drive_type exp_d;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_drives.size() == 0) begin
            if (error_count < SHOW_MAX)
               $display("unexpected transaction: speed %0d changed %0b",
                        $signed(rsp_tdata[SPEED_W-1:0]), rsp_tuser);
            error_count++;
         end else begin
            exp_d = pending_drives.pop_front();
            if (rsp_tdata[SPEED_W-1:0] !== exp_d.speed || rsp_tuser !== exp_d.changed) begin
               if (error_count < SHOW_MAX)
                  $display("wrong result: expected speed %0d changed %0b, got speed %0d changed %0b",
                           exp_d.speed, exp_d.changed,
                           $signed(rsp_tdata[SPEED_W-1:0]), rsp_tuser);
               error_count++;
            end
         end
      end
   end

   // watchdog on cycles without any accepted transaction
   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) || (csr_valid && csr_ready))
         idle_cycles = 0;
      else
         idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
         $display("quadratic_speed_ramp: mismatch");
         $finish;
      end
   end

   initial begin
      clock         = 1'b0;
      reset         = 1'b1;
      req_tvalid    = 1'b0;
      req_tdata     = '0;
      req_tuser     = ACT_SET;
      csr_valid     = 1'b0;
      csr_index     = REG_ACCEL;
      csr_data      = '0;
      tb_now        = '0;
      model_speed   = '0;
      model_goal    = '0;
      model_last_ms = '0;
      model_accel   = RATE_RESET;
      model_decel   = RATE_RESET;
      repeat (RESET_CYCLES) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      test_profile_defaults();
      test_rate_extremes();
      repeat (4) test_random_ramps(RANDOM_ITEMS);
      test_backpressure();

      wait_idle();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (pending_drives.size() != 0) begin
         $display("%0d results never arrived", pending_drives.size());
         error_count = error_count + pending_drives.size();
      end
      if (error_count == 0)
         $display("quadratic_speed_ramp: match");
      else
         $display("quadratic_speed_ramp: mismatch");
      $finish;
   end

endmodule
